/* rtl/core/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, constants and the CRC7 byte update for the SPI-mode SD command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
  localparam logic [7:0]  BYTE_BUSY   = 8'h00;
  localparam logic [7:0]  CRC7_POLY   = 8'h09;
  localparam logic [39:0] RESP_ONES   = 40'hFF_FFFF_FFFF;
  localparam logic [3:0]  POLL_RETRY  = 4'd8;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_RX    = 1'b1;

  localparam logic [2:0] KIND_R1  = 3'd0;
  localparam logic [2:0] KIND_R1B = 3'd1;
  localparam logic [2:0] KIND_R2  = 3'd2;
  localparam logic [2:0] KIND_R3  = 3'd3;
  localparam logic [2:0] KIND_R7  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL,
    PH_COLLECT,
    PH_BUSY
  } phase_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  cmd_byte;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_kind;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [39:0] response;
    logic        timed_out;
    logic        last;
  } out_item_t;

  // MSB-first CRC7 update, 8-bit register, polynomial in the low bits
  function automatic logic [7:0] crc7_byte(input logic [7:0] data, input logic [7:0] prev);
    logic [7:0] crc;
    logic [7:0] d;
    crc = prev;
    d   = data;
    for (int b = 0; b < 8; b++) begin
      crc = {crc[6:0], 1'b0};
      if (d[7] ^ crc[7]) begin
        crc = crc ^ CRC7_POLY;
      end
      d = {d[6:0], 1'b0};
    end
    return crc;
  endfunction

  function automatic logic [2:0] resp_len(input logic [2:0] kind);
    logic [2:0] len;
    if (kind == KIND_R2) begin
      len = 3'd2;
    end else if (kind == KIND_R3 || kind == KIND_R7) begin
      len = 3'd5;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic out_item_t tx_item(input logic [7:0] b, input logic lst);
    out_item_t r;
    r.tx_valid  = 1'b1;
    r.tx_byte   = b;
    r.done_res  = 1'b0;
    r.response  = '0;
    r.timed_out = 1'b0;
    r.last      = lst;
    return r;
  endfunction

endpackage

/* rtl/core/sd_spi_command_transaction.sv */
// ----------------------------------------------------------------------------
// sd_spi_command_transaction
// SPI-mode SD command engine: frames command bytes with CRC7 and tracks the
// card's response through poll, collect and busy-wait phases.
// ----------------------------------------------------------------------------
// The first result is registered in the cycle after a transaction is accepted.
// Throughput: one received-byte transaction per cycle while the output is not
//   stalled; a command transaction emits seven results, one per unstalled cycle,
//   and input stalls until the last one is loaded into the output register.
// Reset: synchronous; returns to idle with the response store all ones.
module sd_spi_command_transaction (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sdspi_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sdspi_pkg::out_item_t out_item
);

  // command frame sequence: argument bytes, then CRC, then the first poll
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_ARG0 = 3'd1;
  localparam logic [2:0] SEQ_ARG3 = 3'd4;
  localparam logic [2:0] SEQ_CRC  = 3'd5;
  localparam logic [2:0] SEQ_POLL = 3'd6;

  logic                 out_free;
  logic                 accept;
  logic                 emit;
  logic                 cmd_start;
  sdspi_pkg::out_item_t res;

  logic [2:0]  seq;
  logic [31:0] arg_sr;
  logic [7:0]  crc;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(out_free && seq == SEQ_NONE);
  assign accept   = in_valid && !in_stall;

  sdspi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_item),
    .emit      (emit),
    .cmd_start (cmd_start),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq       <= SEQ_NONE;
    end else if (out_free) begin
      if (seq != SEQ_NONE) begin
        out_valid <= 1'b1;
        seq       <= (seq == SEQ_POLL) ? SEQ_NONE : seq + 3'd1;
      end else if (accept && emit) begin
        out_valid <= 1'b1;
        if (cmd_start) begin
          seq <= SEQ_ARG0;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (seq != SEQ_NONE) begin
        if (seq >= SEQ_ARG0 && seq <= SEQ_ARG3) begin
          out_item <= sdspi_pkg::tx_item(arg_sr[31:24], 1'b0);
          arg_sr   <= {arg_sr[23:0], 8'h00};
          crc      <= sdspi_pkg::crc7_byte(arg_sr[31:24], crc);
        end else if (seq == SEQ_CRC) begin
          out_item <= sdspi_pkg::tx_item({crc[6:0], 1'b1}, 1'b0);
        end else begin
          out_item <= sdspi_pkg::tx_item(sdspi_pkg::BYTE_IDLE, 1'b1);
        end
      end else if (accept && emit) begin
        out_item <= res;
        if (cmd_start) begin
          arg_sr <= in_item.cmd_arg;
          crc    <= sdspi_pkg::crc7_byte(in_item.cmd_byte, 8'h00);
        end
      end
    end
  end

endmodule

/* rtl/core/sdspi_ctrl.sv */
// ----------------------------------------------------------------------------
// sdspi_ctrl
// Response tracking: poll, collect and busy-wait phases, one step per
// accepted transaction. Produces at most one result and flags command starts.
// ----------------------------------------------------------------------------
module sdspi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  sdspi_pkg::in_item_t  item,
  output logic                 emit,
  output logic                 cmd_start,
  output sdspi_pkg::out_item_t res
);

  sdspi_pkg::phase_t phase, phase_next;
  logic [2:0]  kind_held, kind_held_next;
  logic [3:0]  poll_left, poll_left_next;
  logic [2:0]  byte_pos, byte_pos_next;
  logic [39:0] resp_store, resp_store_next;
  logic        tmo, tmo_next;

  logic        rx_idle;
  logic        first_done;
  logic [2:0]  pos_inc;
  logic [2:0]  kind_len;
  logic [39:0] resp_upd;
  logic        tmo_upd;

  assign rx_idle    = (item.rx_byte == sdspi_pkg::BYTE_IDLE);
  assign first_done = !rx_idle || (poll_left == '0);
  assign pos_inc    = byte_pos + 3'd1;
  assign kind_len   = sdspi_pkg::resp_len(kind_held);

  // response store with this step's received byte merged in
  always_comb begin
    resp_upd = resp_store;
    tmo_upd  = tmo;
    unique case (phase)
      sdspi_pkg::PH_POLL: begin
        if (!rx_idle) begin
          resp_upd[39:32] = item.rx_byte;
        end else if (poll_left == '0) begin
          tmo_upd = 1'b1;
        end
      end
      sdspi_pkg::PH_COLLECT: begin
        unique case (byte_pos)
          3'd0:    resp_upd[39:32] = item.rx_byte;
          3'd1:    resp_upd[31:24] = item.rx_byte;
          3'd2:    resp_upd[23:16] = item.rx_byte;
          3'd3:    resp_upd[15:8]  = item.rx_byte;
          3'd4:    resp_upd[7:0]   = item.rx_byte;
          default: resp_upd        = resp_store;
        endcase
      end
      default: begin
        resp_upd = resp_store;
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        sdspi_pkg::PH_IDLE: begin
          if (item.op == sdspi_pkg::OP_START) begin
            phase_next = sdspi_pkg::PH_POLL;
          end
        end
        sdspi_pkg::PH_POLL: begin
          if (item.op == sdspi_pkg::OP_RX && first_done) begin
            if (kind_len > 3'd1) begin
              phase_next = sdspi_pkg::PH_COLLECT;
            end else if (kind_held == sdspi_pkg::KIND_R1B) begin
              phase_next = sdspi_pkg::PH_BUSY;
            end else begin
              phase_next = sdspi_pkg::PH_IDLE;
            end
          end
        end
        sdspi_pkg::PH_COLLECT: begin
          if (item.op == sdspi_pkg::OP_RX && pos_inc >= kind_len) begin
            phase_next = sdspi_pkg::PH_IDLE;
          end
        end
        sdspi_pkg::PH_BUSY: begin
          if (item.op == sdspi_pkg::OP_RX && item.rx_byte != sdspi_pkg::BYTE_BUSY) begin
            phase_next = sdspi_pkg::PH_IDLE;
          end
        end
        default: phase_next = sdspi_pkg::PH_IDLE;
      endcase
    end
  end

  // outputs and datapath registers
  always_comb begin
    emit            = 1'b0;
    cmd_start       = 1'b0;
    res             = sdspi_pkg::tx_item(sdspi_pkg::BYTE_IDLE, 1'b1);
    kind_held_next  = kind_held;
    poll_left_next  = poll_left;
    byte_pos_next   = byte_pos;
    resp_store_next = resp_store;
    tmo_next        = tmo;
    if (accept) begin
      if (item.op == sdspi_pkg::OP_START) begin
        if (phase == sdspi_pkg::PH_IDLE) begin
          emit            = 1'b1;
          cmd_start       = 1'b1;
          res             = sdspi_pkg::tx_item(item.cmd_byte, 1'b0);
          kind_held_next  = item.resp_kind;
          poll_left_next  = sdspi_pkg::POLL_RETRY;
          byte_pos_next   = '0;
          resp_store_next = sdspi_pkg::RESP_ONES;
          tmo_next        = 1'b0;
        end
      end else if (phase != sdspi_pkg::PH_IDLE) begin
        emit            = 1'b1;
        resp_store_next = resp_upd;
        tmo_next        = tmo_upd;
        unique case (phase)
          sdspi_pkg::PH_POLL: begin
            if (first_done) begin
              byte_pos_next = 3'd1;
            end else begin
              poll_left_next = poll_left - 4'd1;
            end
          end
          sdspi_pkg::PH_COLLECT: begin
            byte_pos_next = pos_inc;
          end
          default: begin
            byte_pos_next = byte_pos;
          end
        endcase
        // a transition into idle ends the transaction
        if (phase_next == sdspi_pkg::PH_IDLE) begin
          res.tx_valid  = 1'b0;
          res.tx_byte   = sdspi_pkg::BYTE_IDLE;
          res.done_res  = 1'b1;
          res.response  = resp_upd;
          res.timed_out = tmo_upd;
          res.last      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sdspi_pkg::PH_IDLE;
      kind_held  <= '0;
      poll_left  <= '0;
      byte_pos   <= '0;
      resp_store <= sdspi_pkg::RESP_ONES;
      tmo        <= 1'b0;
    end else begin
      phase      <= phase_next;
      kind_held  <= kind_held_next;
      poll_left  <= poll_left_next;
      byte_pos   <= byte_pos_next;
      resp_store <= resp_store_next;
      tmo        <= tmo_next;
    end
  end

endmodule
